>>> hw/rtl/polar_unwarp_coordinate_map_unit_macros.svh
// Assertion helpers shared by the unwarp pipeline modules.
// Each module that uses them has ports named clk and rst.
`ifndef POLAR_UNWARP_COORDINATE_MAP_UNIT_MACROS_SVH
`define POLAR_UNWARP_COORDINATE_MAP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PUD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pud assertion failed");
`define PUD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pud assertion failed");
`else
`define PUD_ASSERT(label, cond)
`define PUD_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> hw/rtl/pud_pkg.sv
package pud_pkg;

  // Field and datapath widths
  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 8;
  localparam int DIM_W     = 13;
  localparam int HALF_W    = 12;
  localparam int RING_W    = 12;
  localparam int ANG_W     = 14;
  localparam int OUT_W     = 21;
  localparam int CFG_IDX_W = 8;
  localparam int PHASE_W   = 20;
  localparam int DIV_STEPS = 32;
  localparam int ANGM_W    = 38;
  localparam int NUM_W     = ANGM_W + PHASE_W;
  localparam int DEN_W     = 37;
  localparam int CORE_W    = PHASE_W - 2;
  localparam int Q30_W     = 30;
  localparam int TRIG_W    = 31;
  localparam int Z_W       = 34;
  localparam int QZ_W      = 17;
  localparam int PROD_W    = RING_W + TRIG_W;
  localparam int RND_SH    = 30 - FRAC_BITS;
  localparam int COORD_W   = OUT_W + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  // Reset values of the configuration and of what is derived from it
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd480;
  localparam logic [HALF_W-1:0] HALF_W_RESET = 12'(WIDTH_RESET >> 1);
  localparam logic [HALF_W-1:0] HALF_H_RESET = 12'(HEIGHT_RESET >> 1);
  localparam logic [HALF_W-1:0] RADIUS_RESET =
    (HALF_W_RESET > HALF_H_RESET) ? HALF_W_RESET : HALF_H_RESET;

  // Angle scaling: 2*pi and its decimal scale
  localparam logic [25:0] TWO_PI_E7 = 26'd62831852;
  localparam logic [23:0] TEN_E7    = 24'd10000000;
  localparam logic [DEN_W-1:0] DEN_RESET =
    DEN_W'(64'(RADIUS_RESET) * 64'(TWO_PI_E7));

  // Turn fraction to Q30 radians: t = 6433*a + floor((76691*a + 39062) / 78125)
  localparam logic [12:0] T_MUL   = 13'd6433;
  localparam logic [16:0] Z_MUL   = 17'd76691;
  localparam logic [15:0] Z_ADD   = 16'd39062;
  localparam logic [16:0] Z_DIV   = 17'd78125;
  localparam int          Z_SHIFT = 40;
  localparam logic [23:0] Z_RECIP = 24'((64'd1 << Z_SHIFT) / 64'd78125);

  localparam logic [TRIG_W-1:0] Q_ONE = 31'd1 << 30;

  // Exact reciprocals for 30-bit dividends: ceil(2^(30+l) / d), 2^l >= d
  localparam logic [31:0] M_DIV3  = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
  localparam logic [31:0] M_DIV5  = 32'(((64'd1 << 33) + 64'd4) / 64'd5);
  localparam logic [31:0] M_DIV7  = 32'(((64'd1 << 33) + 64'd6) / 64'd7);
  localparam logic [31:0] M_DIV9  = 32'(((64'd1 << 34) + 64'd8) / 64'd9);
  localparam logic [31:0] M_DIV15 = 32'(((64'd1 << 34) + 64'd14) / 64'd15);
  localparam logic [31:0] M_DIV21 = 32'(((64'd1 << 35) + 64'd20) / 64'd21);
  localparam logic [31:0] M_DIV45 = 32'(((64'd1 << 36) + 64'd44) / 64'd45);

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  // Per-item context that rides along the pipeline
  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic              outside;
    quad_t             quad;
    logic              swap;
  } pud_side_t;

  // Floor division of a 30-bit value by a small constant through its reciprocal
  function automatic logic [Q30_W-1:0] div_const(input logic [Q30_W-1:0] x,
                                                 input logic [31:0] m,
                                                 input int unsigned sh);
    logic [61:0] prod;
    prod = 62'(x) * 62'(m);
    return Q30_W'(prod >> sh);
  endfunction

  // Q30 product, truncated
  function automatic logic [Q30_W-1:0] mul_q30(input logic [Q30_W-1:0] a,
                                               input logic [TRIG_W-1:0] b);
    logic [60:0] prod;
    prod = 61'(a) * 61'(b);
    return Q30_W'(prod >> 30);
  endfunction

  function automatic logic [TRIG_W-1:0] one_minus(input logic [Q30_W-1:0] x);
    return Q_ONE - TRIG_W'(x);
  endfunction

endpackage

>>> hw/rtl/pud_phase_div.sv
`include "polar_unwarp_coordinate_map_unit_macros.svh"

module pud_phase_div
  import pud_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   numer,
  input  logic [DEN_W-1:0]   den,
  input  pud_side_t          in_side,
  output logic               out_valid,
  output logic [PHASE_W-1:0] quot,
  output pud_side_t          out_side
);

  logic                 v_p    [DIV_STEPS];
  logic [DEN_W-1:0]     rem_p  [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_p  [DIV_STEPS];
  logic [PHASE_W-1:0]   quo_p  [DIV_STEPS];
  pud_side_t            side_p [DIV_STEPS];

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 v_in;
    logic [DEN_W-1:0]     rem_in;
    logic [DIV_STEPS-1:0] low_in;
    logic [PHASE_W-1:0]   quo_in;
    pud_side_t            side_in;
    logic [DEN_W:0]       trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = DEN_W'(numer[NUM_W-1:DIV_STEPS]);
      assign low_in  = numer[DIV_STEPS-1:0];
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_p[k-1];
      assign rem_in  = rem_p[k-1];
      assign low_in  = low_p[k-1];
      assign quo_in  = quo_p[k-1];
      assign side_in = side_p[k-1];
    end

    assign trial = {rem_in, low_in[DIV_STEPS-1]};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k] <= 1'b0;
      end else if (advance) begin
        v_p[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_p[k]  <= take ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        low_p[k]  <= {low_in[DIV_STEPS-2:0], 1'b0};
        quo_p[k]  <= {quo_in[PHASE_W-2:0], take};
        side_p[k] <= side_in;
      end
    end
  end

  assign out_valid = v_p[DIV_STEPS-1];
  assign quot      = quo_p[DIV_STEPS-1];
  assign out_side  = side_p[DIV_STEPS-1];

  `PUD_ASSERT(a_rem_below_den, !out_valid || den == '0 || rem_p[DIV_STEPS-1] < den)

endmodule

>>> hw/rtl/pud_sincos.sv
`include "polar_unwarp_coordinate_map_unit_macros.svh"

module pud_sincos
  import pud_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [CORE_W-1:0] core_angle,
  input  pud_side_t         in_side,
  output logic              out_valid,
  output logic [TRIG_W-1:0] sin_mag,
  output logic [TRIG_W-1:0] cos_mag,
  output pud_side_t         out_side
);

  localparam int STAGES = 13;

  logic             v_p    [1:STAGES];
  pud_side_t        side_p [1:STAGES];
  logic [Q30_W-1:0] t_p    [4:STAGES-1];
  logic [Q30_W-1:0] t2_p   [5:STAGES-1];

  logic [Z_W-1:0]   z_s1, z_s2, z_s3, qd_s3;
  logic [Q30_W-1:0] thi_s1, thi_s2, thi_s3;
  logic [QZ_W-1:0]  q0_s2, q0_s3;
  logic             corr;
  logic [Q30_W-1:0] ds_s6, dc_s6, ms_s7, mc_s7;
  logic [Q30_W-1:0] ds_s8, dc_s8, ms_s9, mc_s9;
  logic [Q30_W-1:0] ds_s10, dc_s10, ms_s11, mc_s11;
  logic [Q30_W-1:0] ds_s12, dc_s12, ms_s13, mc_s13;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STAGES; k++) v_p[k] <= 1'b0;
    end else if (advance) begin
      v_p[1] <= in_valid;
      for (int k = 2; k <= STAGES; k++) v_p[k] <= v_p[k-1];
    end
  end

  // Estimate is low by at most one
  assign corr = (z_s3 - qd_s3) >= Z_W'(Z_DIV);

  always_ff @(posedge clk) begin
    if (advance) begin
      side_p[1] <= in_side;
      for (int k = 2; k <= STAGES; k++) side_p[k] <= side_p[k-1];
      for (int k = 5; k <= STAGES - 1; k++) t_p[k] <= t_p[k-1];
      for (int k = 6; k <= STAGES - 1; k++) t2_p[k] <= t2_p[k-1];

      // Turn fraction to Q30 radians
      z_s1   <= Z_W'(Z_W'(core_angle) * Z_W'(Z_MUL)) + Z_W'(Z_ADD);
      thi_s1 <= Q30_W'(core_angle) * Q30_W'(T_MUL);
      q0_s2  <= QZ_W'((58'(z_s1) * 58'(Z_RECIP)) >> Z_SHIFT);
      z_s2   <= z_s1;
      thi_s2 <= thi_s1;
      qd_s3  <= Z_W'(q0_s2) * Z_W'(Z_DIV);
      z_s3   <= z_s2;
      q0_s3  <= q0_s2;
      thi_s3 <= thi_s2;
      t_p[4] <= thi_s3 + Q30_W'(q0_s3) + Q30_W'(corr);

      // Square of the angle
      t2_p[5] <= Q30_W'((60'(t_p[4]) * 60'(t_p[4])) >> 30);

      // Horner steps, sine and cosine side by side
      ds_s6  <= div_const(t2_p[5] >> 3, M_DIV9, 34);
      dc_s6  <= div_const(t2_p[5] >> 1, M_DIV45, 36);
      ms_s7  <= mul_q30(t2_p[6], one_minus(ds_s6));
      mc_s7  <= mul_q30(t2_p[6], one_minus(dc_s6));
      ds_s8  <= div_const(ms_s7 >> 1, M_DIV21, 35);
      dc_s8  <= div_const(mc_s7 >> 3, M_DIV7, 33);
      ms_s9  <= mul_q30(t2_p[8], one_minus(ds_s8));
      mc_s9  <= mul_q30(t2_p[8], one_minus(dc_s8));
      ds_s10 <= div_const(ms_s9 >> 2, M_DIV5, 33);
      dc_s10 <= div_const(mc_s9 >> 1, M_DIV15, 34);
      ms_s11 <= mul_q30(t2_p[10], one_minus(ds_s10));
      mc_s11 <= mul_q30(t2_p[10], one_minus(dc_s10));
      ds_s12 <= div_const(ms_s11 >> 1, M_DIV3, 32);
      dc_s12 <= div_const(mc_s11 >> 2, M_DIV3, 32);
      ms_s13 <= mul_q30(t_p[12], one_minus(ds_s12));
      mc_s13 <= mul_q30(t2_p[12], one_minus(dc_s12));
    end
  end

  assign out_valid = v_p[STAGES];
  assign out_side  = side_p[STAGES];
  assign sin_mag   = TRIG_W'(ms_s13);
  assign cos_mag   = Q_ONE - TRIG_W'(mc_s13 >> 1);

  `PUD_ASSERT(a_recip_within_one, !v_p[3] || (z_s3 - qd_s3) < Z_W'(2 * Z_DIV))
  `PUD_ASSERT(a_trig_unit_range, !out_valid || (sin_mag <= Q_ONE && cos_mag <= Q_ONE))

endmodule

>>> hw/rtl/polar_unwarp_coordinate_map_unit.sv
// Source-coordinate generator for unwrapping a circular image into a strip.
// Slave stream: one beat per strip pixel, tdata holds ring_index and
// angle_index. Master stream: one beat per input beat, in order, with
// source_x and source_y in signed fixed point (8 fraction bits) and the
// outside_map flag in tuser.
// Configuration channel: index 0 writes image_width, index 1 image_height,
// other indexes are dropped; it is always ready. The user must write it only
// while the pipeline holds no beat; the block itself does not enforce this.
// Throughput: one beat per clock while the master side does not stall.
// Depth is set by the 32-stage phase divider (one quotient bit per stage)
// plus the 13-stage sine/cosine unit and the coordinate multiply and round
// stages.
// Reset: synchronous; clears all valid bits and loads 640 by 480.
// Stall: while master tvalid is high and tready low, the whole pipeline
// holds and slave tready is low; nothing is lost or repeated.
`include "polar_unwarp_coordinate_map_unit_macros.svh"

module polar_unwarp_coordinate_map_unit
  import pud_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // tdata: ring_index[11:0], angle_index[25:12], zero fill
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,
  // tdata: source_x[20:0], source_y[41:21], zero fill
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,
  // tuser: outside_map[0]
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam logic signed [COORD_W-1:0] COORD_MIN = -(COORD_W'(1) << (OUT_W - 1));
  localparam logic signed [COORD_W-1:0] COORD_MAX = (COORD_W'(1) << (OUT_W - 1)) - 1;

  logic                  advance;
  logic [DIM_W-1:0]      image_width, image_height;
  logic [DIM_W-1:0]      w_clamp, h_clamp;
  logic [HALF_W-1:0]     half_w_c, half_h_c, radius_c;
  logic [HALF_W-1:0]     half_w_q, half_h_q, radius_q;
  logic [DEN_W-1:0]      den_q;

  logic                  v1, v2, v3, v4, v5;
  logic [RING_W-1:0]     ring1;
  logic [ANGM_W-1:0]     angm1;
  logic [NUM_W-1:0]      numer2;
  pud_side_t             side2, side3;
  logic [CORE_W-1:0]     a3;

  logic                  div_valid;
  logic [PHASE_W-1:0]    div_quot;
  pud_side_t             div_side;
  logic [PHASE_W-1:0]    phase;
  logic [CORE_W-1:0]     phase_u;

  logic                  sc_valid;
  logic [TRIG_W-1:0]     sc_sin, sc_cos;
  pud_side_t             sc_side;
  logic [TRIG_W-1:0]     s0, c0;

  logic [TRIG_W-1:0]     xmag4, ymag4;
  logic                  xneg4, yneg4, out4;
  logic [RING_W-1:0]     ring4;
  logic [PROD_W-1:0]     xprod5, yprod5;
  logic                  xneg5, yneg5, out5;
  logic [OUT_W-1:0]      src_x, src_y;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign cfg_ready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Half sizes, radius limit and divisor, registered behind the configuration registers
  assign w_clamp  = (image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
  assign h_clamp  = (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
  assign half_w_c = HALF_W'(w_clamp >> 1);
  assign half_h_c = HALF_W'(h_clamp >> 1);
  assign radius_c = (half_w_c > half_h_c) ? half_w_c : half_h_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_w_q <= HALF_W_RESET;
      half_h_q <= HALF_H_RESET;
      radius_q <= RADIUS_RESET;
      den_q    <= DEN_RESET;
    end else begin
      half_w_q <= half_w_c;
      half_h_q <= half_h_c;
      radius_q <= radius_c;
      den_q    <= DEN_W'(DEN_W'(radius_c) * DEN_W'(TWO_PI_E7));
    end
  end

  // Front stages: scale the angle, then build the dividend and the range flag
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= div_valid;
    end
  end

  assign phase   = (radius_q == '0) ? '0 : div_quot;
  assign phase_u = phase[CORE_W-1:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      ring1 <= s_axis_tdata[RING_W-1:0];
      angm1 <= ANGM_W'(s_axis_tdata[RING_W+ANG_W-1:RING_W]) * ANGM_W'(TEN_E7);

      numer2        <= {angm1, PHASE_W'(0)} + NUM_W'(den_q >> 1);
      side2.ring    <= ring1;
      side2.outside <= (ring1 >= radius_q) ||
                       ((39'(angm1) + 39'(TEN_E7)) > 39'(den_q));
      side2.quad    <= QUAD_I;
      side2.swap    <= 1'b0;

      // Fold the phase into one octant
      side3.ring    <= div_side.ring;
      side3.outside <= div_side.outside;
      side3.quad    <= quad_t'(phase[PHASE_W-1:CORE_W]);
      side3.swap    <= phase_u[CORE_W-1];
      a3            <= phase_u[CORE_W-1] ? CORE_W'((19'd1 << CORE_W) - 19'(phase_u))
                                         : phase_u;
    end
  end

  pud_phase_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v2),
    .numer     (numer2),
    .den       (den_q),
    .in_side   (side2),
    .out_valid (div_valid),
    .quot      (div_quot),
    .out_side  (div_side)
  );

  pud_sincos u_sincos (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (v3),
    .core_angle (a3),
    .in_side    (side3),
    .out_valid  (sc_valid),
    .sin_mag    (sc_sin),
    .cos_mag    (sc_cos),
    .out_side   (sc_side)
  );

  // Undo the octant fold
  assign s0 = sc_side.swap ? sc_cos : sc_sin;
  assign c0 = sc_side.swap ? sc_sin : sc_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v4 <= sc_valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ring4 <= sc_side.ring;
      out4  <= sc_side.outside;
      case (sc_side.quad)
        QUAD_I: begin
          xmag4 <= s0; xneg4 <= 1'b0; ymag4 <= c0; yneg4 <= 1'b0;
        end
        QUAD_II: begin
          xmag4 <= c0; xneg4 <= 1'b0; ymag4 <= s0; yneg4 <= 1'b1;
        end
        QUAD_III: begin
          xmag4 <= s0; xneg4 <= 1'b1; ymag4 <= c0; yneg4 <= 1'b1;
        end
        default: begin
          xmag4 <= c0; xneg4 <= 1'b1; ymag4 <= s0; yneg4 <= 1'b0;
        end
      endcase

      xprod5 <= PROD_W'(ring4) * PROD_W'(xmag4);
      yprod5 <= PROD_W'(ring4) * PROD_W'(ymag4);
      xneg5  <= xneg4;
      yneg5  <= yneg4;
      out5   <= out4;
    end
  end

  // Round the offset, apply it to the center and saturate
  function automatic logic [OUT_W-1:0] coord(input logic [HALF_W-1:0] half,
                                             input logic [PROD_W-1:0] prod,
                                             input logic neg);
    logic [OUT_W-1:0]          rnd;
    logic signed [COORD_W-1:0] base;
    logic signed [COORD_W-1:0] val;
    rnd  = OUT_W'((prod + (PROD_W'(1) << (RND_SH - 1))) >> RND_SH);
    base = signed'(COORD_W'(half) << FRAC_BITS);
    val  = neg ? base + signed'(COORD_W'(rnd)) : base - signed'(COORD_W'(rnd));
    if (val < COORD_MIN) val = COORD_MIN;
    if (val > COORD_MAX) val = COORD_MAX;
    return val[OUT_W-1:0];
  endfunction

  assign src_x = coord(half_w_q, xprod5, xneg5);
  assign src_y = coord(half_h_q, yprod5, yneg5);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {6'd0, src_y, src_x};
      m_axis_tuser <= out5;
    end
  end

  `PUD_ASSERT(a_radius_is_max, radius_q == ((half_w_q > half_h_q) ? half_w_q : half_h_q))
  `PUD_ASSERT_NEXT(a_front_holds, v1 && !advance, v1 && $stable(angm1) && $stable(ring1))

endmodule
